// ===== hw/rtl/pts_pkg.sv =====
// Shared types and codes for the periodic task slot scheduler.
`default_nettype none

package pts_pkg;

    // Operation codes carried in func
    localparam logic [2:0] FN_ADD        = 3'd0;
    localparam logic [2:0] FN_REMOVE     = 3'd1;
    localparam logic [2:0] FN_TICK       = 3'd2;
    localparam logic [2:0] FN_PROCESS    = 3'd3;
    localparam logic [2:0] FN_REMOVE_ALL = 3'd4;
    localparam logic [2:0] FN_QUERY      = 3'd5;

    // Result kinds
    localparam logic [2:0] KD_ADDED   = 3'd0;
    localparam logic [2:0] KD_REMOVED = 3'd1;
    localparam logic [2:0] KD_TICKED  = 3'd2;
    localparam logic [2:0] KD_FIRED   = 3'd3;
    localparam logic [2:0] KD_NONE    = 3'd4;
    localparam logic [2:0] KD_QUERY   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Slot limit register after reset
    localparam logic [4:0] SLOT_LIMIT_RST = 5'd16;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] period_in;
        logic [7:0]  tag_in;
        logic [3:0]  slot_in;
        logic [15:0] tick_count;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  status;
        logic [3:0]  slot_out;
        logic [7:0]  tag_out;
        logic [15:0] period_out;
        logic [15:0] elapsed_out;
        logic [4:0]  free_slots;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_EXEC,
        S_FIND,
        S_SCAN,
        S_QWAIT,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/pts_out_reg.sv =====
// Output register that holds one result item until the consumer takes it.
`default_nettype none

module pts_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push_vld,
    input  wire pts_pkg::t_out_item i_push_item,
    output logic                   o_push_rdy,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output pts_pkg::t_out_item     o_out_item
);

    logic               r_vld;
    pts_pkg::t_out_item r_item;

    // Take a new item when empty or when the held one leaves this cycle
    assign o_push_rdy = !r_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_push_rdy) begin
            r_vld <= i_push_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push_rdy && i_push_vld) begin
            r_item <= i_push_item;
        end
    end

    assign o_out_valid = r_vld;
    assign o_out_item  = r_item;

endmodule

`default_nettype wire

// ===== hw/rtl/pts_ctrl.sv =====
// Sequencer, valid bits and slot memory of the periodic task slot scheduler.
`default_nettype none

module pts_ctrl #(
    parameter int NUM_SLOTS = 16,
    parameter int TICK_BITS = 16,
    parameter int TAG_BITS  = 8,
    localparam int IW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    localparam int CW  = $clog2(NUM_SLOTS + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [CW-1:0]     i_lim,
    input  wire logic              i_cfg_we,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire pts_pkg::t_in_item i_in_item,
    output logic                   o_push_vld,
    output pts_pkg::t_out_item     o_push_item,
    input  wire logic              i_push_rdy
);

    localparam int LW   = (CW > 5) ? CW : 5;
    localparam int SW   = (IW > 4) ? IW : 4;
    localparam int PX   = (TICK_BITS > 16) ? TICK_BITS : 16;
    localparam int TGX  = (TAG_BITS > 8) ? TAG_BITS : 8;
    localparam int SUMW = PX + 1;
    localparam int DW   = 2 * TICK_BITS + TAG_BITS;
    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    // Control state
    pts_pkg::t_state        r_state, n_state;
    pts_pkg::t_in_item      r_item;
    pts_pkg::t_out_item     r_res;
    logic [NUM_SLOTS-1:0]   r_valid;
    logic [CW-1:0]          r_idx;
    logic [CW-1:0]          r_free;
    logic                   r_recount;
    logic                   r_s1_vld;
    logic [IW-1:0]          r_s1_idx;
    logic                   r_pend_vld;
    logic [IW-1:0]          r_pend_slot;
    logic [TAG_BITS-1:0]    r_pend_tag;

    // Slot memory: {period, elapsed, tag}
    logic [DW-1:0]          mem [NUM_SLOTS];
    logic [DW-1:0]          r_rd_data;
    logic                   rd_en, wr_en;
    logic [IW-1:0]          rd_addr, wr_addr;
    logic [DW-1:0]          wr_data;

    logic                   accept;
    logic [2:0]             op;
    logic [IW-1:0]          idx_lo;
    logic                   idx_in_lim;
    logic [SW-1:0]          slot_ext;
    logic [IW-1:0]          slot_idx;
    logic                   slot_ok;
    logic [TICK_BITS-1:0]   rd_period, rd_elapsed;
    logic [TAG_BITS-1:0]    rd_tag;
    logic [PX-1:0]          period_ext;
    logic [TGX-1:0]         tag_ext;
    logic [TICK_BITS-1:0]   period_st;
    logic [TAG_BITS-1:0]    tag_st;
    logic [SUMW-1:0]        tick_sum;
    logic [TICK_BITS-1:0]   tick_sat;
    logic                   s1_slot_vld;
    logic                   s1_fire, s1_tick, stall;
    logic [LW-1:0]          free_ext;
    logic [4:0]             free5;
    logic                   scan_end;

    function automatic logic [3:0] slot4(input logic [IW-1:0] s);
        logic [SW-1:0] e;
        e = SW'(s);
        return e[3:0];
    endfunction

    function automatic logic [7:0] tag8(input logic [TAG_BITS-1:0] t);
        logic [TGX-1:0] e;
        e = TGX'(t);
        return e[7:0];
    endfunction

    function automatic logic [15:0] tick16(input logic [TICK_BITS-1:0] t);
        logic [PX-1:0] e;
        e = PX'(t);
        return e[15:0];
    endfunction

    // Decode the held item and the memory read data
    always_comb begin
        accept      = i_in_valid && o_in_ready;
        op          = r_item.func;
        idx_lo      = r_idx[IW-1:0];
        idx_in_lim  = r_idx < i_lim;
        slot_ext    = SW'(r_item.slot_in);
        slot_idx    = slot_ext[IW-1:0];
        slot_ok     = (LW'(r_item.slot_in) < LW'(i_lim)) && r_valid[slot_idx];
        rd_period   = r_rd_data[DW-1 -: TICK_BITS];
        rd_elapsed  = r_rd_data[TAG_BITS +: TICK_BITS];
        rd_tag      = r_rd_data[TAG_BITS-1:0];
        period_ext  = PX'(r_item.period_in);
        period_st   = period_ext[TICK_BITS-1:0];
        tag_ext     = TGX'(r_item.tag_in);
        tag_st      = tag_ext[TAG_BITS-1:0];
        tick_sum    = SUMW'(rd_elapsed) + SUMW'(r_item.tick_count);
        tick_sat    = (tick_sum > SUMW'(TICK_MAX)) ? TICK_MAX : tick_sum[TICK_BITS-1:0];
        s1_slot_vld = r_valid[r_s1_idx];
        s1_fire     = r_s1_vld && (op == pts_pkg::FN_PROCESS) && s1_slot_vld
                      && (rd_elapsed >= rd_period);
        s1_tick     = r_s1_vld && (op == pts_pkg::FN_TICK) && s1_slot_vld;
        stall       = s1_fire && r_pend_vld && !i_push_rdy;
        free_ext    = LW'(r_free);
        free5       = free_ext[4:0];
        scan_end    = !idx_in_lim && !r_s1_vld;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pts_pkg::S_IDLE: begin
                if (accept && (i_in_item.func <= pts_pkg::FN_QUERY)) begin
                    n_state = r_recount ? pts_pkg::S_COUNT : pts_pkg::S_EXEC;
                end
            end
            pts_pkg::S_COUNT: begin
                if (!idx_in_lim) begin
                    n_state = pts_pkg::S_EXEC;
                end
            end
            pts_pkg::S_EXEC: begin
                case (op) inside
                    pts_pkg::FN_ADD:                        n_state = pts_pkg::S_FIND;
                    pts_pkg::FN_TICK, pts_pkg::FN_PROCESS:  n_state = pts_pkg::S_SCAN;
                    pts_pkg::FN_QUERY: begin
                        n_state = slot_ok ? pts_pkg::S_QWAIT : pts_pkg::S_EMIT;
                    end
                    default:                                n_state = pts_pkg::S_EMIT;
                endcase
            end
            pts_pkg::S_FIND: begin
                if (!idx_in_lim || !r_valid[idx_lo]) begin
                    n_state = pts_pkg::S_EMIT;
                end
            end
            pts_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_state = pts_pkg::S_EMIT;
                end
            end
            pts_pkg::S_QWAIT: n_state = pts_pkg::S_EMIT;
            pts_pkg::S_EMIT: begin
                if (i_push_rdy) begin
                    n_state = pts_pkg::S_IDLE;
                end
            end
            default: n_state = pts_pkg::S_IDLE;
        endcase
    end

    // Memory accesses, result pushes and input ready
    always_comb begin
        o_in_ready  = (r_state == pts_pkg::S_IDLE);
        rd_en       = 1'b0;
        rd_addr     = idx_lo;
        wr_en       = 1'b0;
        wr_addr     = r_s1_idx;
        wr_data     = {rd_period, tick_sat, rd_tag};
        o_push_vld  = 1'b0;
        o_push_item = r_res;
        unique case (r_state)
            pts_pkg::S_EXEC: begin
                if (op == pts_pkg::FN_QUERY) begin
                    rd_en   = slot_ok;
                    rd_addr = slot_idx;
                end
            end
            pts_pkg::S_FIND: begin
                wr_en   = idx_in_lim && !r_valid[idx_lo];
                wr_addr = idx_lo;
                wr_data = {period_st, {TICK_BITS{1'b0}}, tag_st};
            end
            pts_pkg::S_SCAN: begin
                rd_en = idx_in_lim && !stall;
                wr_en = !stall && (s1_fire || s1_tick);
                if (s1_fire) begin
                    wr_data = {rd_period, {TICK_BITS{1'b0}}, rd_tag};
                end
                // Push the earlier fired slot once a later one proves it is not last
                o_push_vld           = s1_fire && r_pend_vld;
                o_push_item          = '0;
                o_push_item.kind     = pts_pkg::KD_FIRED;
                o_push_item.status   = pts_pkg::ST_OK;
                o_push_item.slot_out = slot4(r_pend_slot);
                o_push_item.tag_out  = tag8(r_pend_tag);
                o_push_item.free_slots = free5;
            end
            pts_pkg::S_EMIT: begin
                o_push_vld             = 1'b1;
                o_push_item.free_slots = free5;
                o_push_item.last       = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Slot memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pts_pkg::S_IDLE;
            r_valid    <= '0;
            r_idx      <= '0;
            r_free     <= '0;
            r_recount  <= 1'b1;
            r_s1_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                pts_pkg::S_IDLE: begin
                    r_idx <= '0;
                    if (accept && r_recount) begin
                        r_free <= '0;
                    end
                    // A new limit invalidates the free count
                    if (i_cfg_we) begin
                        r_recount <= 1'b1;
                    end
                end
                pts_pkg::S_COUNT: begin
                    if (idx_in_lim) begin
                        r_idx  <= r_idx + 1'b1;
                        r_free <= r_free + CW'(!r_valid[idx_lo]);
                    end else begin
                        r_idx     <= '0;
                        r_recount <= 1'b0;
                    end
                end
                pts_pkg::S_EXEC: begin
                    r_s1_vld   <= 1'b0;
                    r_pend_vld <= 1'b0;
                    if (op == pts_pkg::FN_REMOVE && slot_ok) begin
                        r_valid[slot_idx] <= 1'b0;
                        r_free            <= r_free + 1'b1;
                    end
                    if (op == pts_pkg::FN_REMOVE_ALL) begin
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            if (CW'(i) < i_lim) begin
                                r_valid[i] <= 1'b0;
                            end
                        end
                        r_free <= i_lim;
                    end
                end
                pts_pkg::S_FIND: begin
                    if (idx_in_lim) begin
                        if (!r_valid[idx_lo]) begin
                            r_valid[idx_lo] <= 1'b1;
                            r_free          <= r_free - 1'b1;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                pts_pkg::S_SCAN: begin
                    if (!stall) begin
                        if (idx_in_lim) begin
                            r_idx <= r_idx + 1'b1;
                        end
                        r_s1_vld <= idx_in_lim;
                        if (s1_fire) begin
                            r_pend_vld <= 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Held item, result and pending fired slot
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
        end
        unique case (r_state)
            pts_pkg::S_EXEC: begin
                r_res          <= '0;
                r_res.slot_out <= r_item.slot_in;
                if (op == pts_pkg::FN_QUERY) begin
                    r_res.kind   <= pts_pkg::KD_QUERY;
                    r_res.status <= pts_pkg::ST_INVALID;
                end else begin
                    r_res.kind   <= pts_pkg::KD_REMOVED;
                    r_res.status <= slot_ok ? pts_pkg::ST_OK : pts_pkg::ST_INVALID;
                end
                if (op == pts_pkg::FN_REMOVE_ALL) begin
                    r_res.status   <= pts_pkg::ST_OK;
                    r_res.slot_out <= '0;
                end
            end
            pts_pkg::S_FIND: begin
                r_res      <= '0;
                r_res.kind <= pts_pkg::KD_ADDED;
                if (!idx_in_lim) begin
                    r_res.status <= pts_pkg::ST_FULL;
                end else begin
                    r_res.slot_out <= slot4(idx_lo);
                end
            end
            pts_pkg::S_SCAN: begin
                if (!stall) begin
                    r_s1_idx <= idx_lo;
                    if (s1_fire) begin
                        r_pend_slot <= r_s1_idx;
                        r_pend_tag  <= rd_tag;
                    end
                end
                if (scan_end) begin
                    r_res <= '0;
                    if (op == pts_pkg::FN_TICK) begin
                        r_res.kind <= pts_pkg::KD_TICKED;
                    end else if (r_pend_vld) begin
                        r_res.kind     <= pts_pkg::KD_FIRED;
                        r_res.slot_out <= slot4(r_pend_slot);
                        r_res.tag_out  <= tag8(r_pend_tag);
                    end else begin
                        r_res.kind <= pts_pkg::KD_NONE;
                    end
                end
            end
            pts_pkg::S_QWAIT: begin
                r_res             <= '0;
                r_res.kind        <= pts_pkg::KD_QUERY;
                r_res.status      <= pts_pkg::ST_OK;
                r_res.slot_out    <= r_item.slot_in;
                r_res.tag_out     <= tag8(rd_tag);
                r_res.period_out  <= tick16(rd_period);
                r_res.elapsed_out <= tick16(rd_elapsed);
            end
            default: begin
            end
        endcase
    end

    // Write-back of one slot never meets the read of the same slot
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("slot memory read and write hit the same entry");

    // The scan pipeline is only occupied during a scan
    a_s1_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (r_state == pts_pkg::S_SCAN))
        else $error("scan stage busy outside a scan");

    // A settled free count never exceeds the active limit
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == pts_pkg::S_IDLE) && !r_recount) |-> (r_free <= i_lim))
        else $error("free slot count above limit");

    // Only a process pass holds a pending fired slot
    a_pend_process: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_vld && (r_state == pts_pkg::S_SCAN)) |-> (op == pts_pkg::FN_PROCESS))
        else $error("pending fired slot outside a process pass");

    // Every result ending an item leaves the block idle next
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == pts_pkg::S_EMIT) && i_push_rdy) |=> (r_state == pts_pkg::S_IDLE))
        else $error("sequencer did not return to idle after last result");

endmodule

`default_nettype wire

// ===== hw/rtl/periodic_task_slot_scheduler_top.sv =====
// Top level of the periodic task slot scheduler: limit register, sequencer, output register.
//
// Holds up to NUM_SLOTS periodic task slots (period, elapsed ticks, tag) in a single-port-write,
// registered-read memory, with one valid flip-flop per slot. One item is worked at a time; each
// scan visits one slot per cycle through the memory read port while no fired result is held
// up by the consumer, writing back the updated slot from the registered read data. Tick and
// process scan every slot below the active slot limit; add stops at the first free slot, or at
// the limit when the table is full; query reads the slot memory only when the slot is in use
// and within the limit. After reset and after every slot limit write, the next item first runs
// a count pass to rebuild the free slot count. Unused operation codes are dropped with no
// result. The slot limit may only be written while no item is in flight; a finished result
// waits in the output register while the next item is taken.
`default_nettype none

module periodic_task_slot_scheduler_top #(
    parameter int NUM_SLOTS = 16,
    parameter int TICK_BITS = 16,
    parameter int TAG_BITS  = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [4:0]     i_cfg_data,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire pts_pkg::t_in_item i_in_item,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output pts_pkg::t_out_item  o_out_item
);

    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int LW = (CW > 5) ? CW : 5;

    logic [4:0]          r_slot_limit;
    logic [LW-1:0]       lim_w;
    logic [CW-1:0]       lim;
    logic                push_vld;
    logic                push_rdy;
    pts_pkg::t_out_item  push_item;

    // Hold the slot limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_limit <= pts_pkg::SLOT_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_slot_limit <= i_cfg_data;
        end
    end

    // Cap the limit at the slot count
    always_comb begin
        lim_w = (LW'(r_slot_limit) > LW'(NUM_SLOTS)) ? LW'(NUM_SLOTS) : LW'(r_slot_limit);
        lim   = lim_w[CW-1:0];
    end

    pts_ctrl #(
        .NUM_SLOTS (NUM_SLOTS),
        .TICK_BITS (TICK_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lim       (lim),
        .i_cfg_we    (i_cfg_we),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_push_vld  (push_vld),
        .o_push_item (push_item),
        .i_push_rdy  (push_rdy)
    );

    pts_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_vld  (push_vld),
        .i_push_item (push_item),
        .o_push_rdy  (push_rdy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
